// File: hw/rtl/mese_pkg.sv
// Package for the MIDI event stream encoder: payload structs, command codes,
// event queue entry type and sizing constants. No dependencies.
package mese_pkg;

    localparam int CHANNELS   = 4;
    localparam int CH_W       = 2;
    localparam int TICK_SHIFT = 14;
    localparam int DELTA_W    = 28;
    localparam int EVQ_DEPTH  = 4;
    localparam int EVQ_PTR_W  = 2;
    localparam int EVQ_CNT_W  = 3;

    localparam logic [DELTA_W-1:0] DELTA_MAX = 28'h0FF_FFFF | 28'hF00_0000;
    // Saturated delta moved back into cycle units.
    localparam logic [63:0] SAT_STEP = 64'h0000_03FF_FFFF_C000;

    localparam logic [2:0] CMD_NOTE_ON  = 3'd0;
    localparam logic [2:0] CMD_NOTE_OFF = 3'd1;
    localparam logic [2:0] CMD_PAN      = 3'd2;
    localparam logic [2:0] CMD_EOT      = 3'd3;
    localparam logic [2:0] CMD_RESTART  = 3'd4;

    localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
    localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
    localparam logic [3:0] STAT_CTRL     = 4'hB;
    localparam logic [7:0] CTRL_PAN      = 8'h0A;
    localparam logic [7:0] META_PREFIX   = 8'hFF;
    localparam logic [7:0] META_EOT      = 8'h2F;

    typedef struct packed {
        logic [2:0]      command;
        logic [63:0]     cycle_time;
        logic [CH_W-1:0] channel;
        logic [6:0]      note_number;
        logic [6:0]      value;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_t;

    // One queued event: delta ticks, index of its top VLQ group, three event bytes.
    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic [1:0]         top;
        logic [7:0]         b0;
        logic [7:0]         b1;
        logic [7:0]         b2;
    } ev_t;

endpackage

// File: hw/rtl/mese_front.sv
// Front end of the MIDI event stream encoder: accepts events, applies mute and
// held-note rules, computes the delta time and keeps the time base. Uses mese_pkg.
module mese_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [3:0]        cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  mese_pkg::in_t     s_data,
    input  logic              q_full,
    output logic              q_push,
    output mese_pkg::ev_t     q_data
);

    logic [3:0]  mute_reg;
    logic [63:0] last_time_reg;
    logic [63:0] last_time_next;
    logic [6:0]  held_reg  [mese_pkg::CHANNELS];
    logic [6:0]  held_next [mese_pkg::CHANNELS];

    logic        accept;
    logic        ch_ok;
    logic        muted;
    logic [63:0] diff;
    logic        sat;
    logic        borrow;
    logic [63:0] lt_adv;
    logic [mese_pkg::DELTA_W-1:0] d;
    logic [1:0]  top;
    logic [6:0]  held_cur;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign ch_ok   = (32'(s_data.channel) < mese_pkg::CHANNELS);
    assign muted   = mute_reg[s_data.channel];
    assign held_cur = held_reg[s_data.channel];

    // Delta in ticks, saturated.
    assign diff = s_data.cycle_time - last_time_reg;
    assign sat  = |diff[63:mese_pkg::TICK_SHIFT+mese_pkg::DELTA_W];
    assign d    = sat ? mese_pkg::DELTA_MAX
                      : diff[mese_pkg::TICK_SHIFT+mese_pkg::DELTA_W-1:mese_pkg::TICK_SHIFT];

    // Advance by the emitted delta: the low tick bits of the old base stay.
    assign borrow = s_data.cycle_time[13:0] < last_time_reg[13:0];
    assign lt_adv = sat ? (last_time_reg + mese_pkg::SAT_STEP)
                        : {s_data.cycle_time[63:14] - 50'(borrow), last_time_reg[13:0]};

    always_comb begin
        if (d[27:21] != 7'd0) begin
            top = 2'd3;
        end else if (d[20:14] != 7'd0) begin
            top = 2'd2;
        end else if (d[13:7] != 7'd0) begin
            top = 2'd1;
        end else begin
            top = 2'd0;
        end
    end

    always_comb begin
        q_push         = 1'b0;
        q_data.delta   = d;
        q_data.top     = top;
        q_data.b0      = 8'h00;
        q_data.b1      = 8'h00;
        q_data.b2      = 8'h00;
        last_time_next = last_time_reg;
        for (int c = 0; c < mese_pkg::CHANNELS; c++) begin
            held_next[c] = held_reg[c];
        end
        if (accept) begin
            case (s_data.command)
                mese_pkg::CMD_NOTE_ON: begin
                    if (ch_ok && !muted) begin
                        q_push         = 1'b1;
                        q_data.b0      = {mese_pkg::STAT_NOTE_ON, 2'b00, s_data.channel};
                        q_data.b1      = {1'b0, s_data.note_number};
                        q_data.b2      = {1'b0, s_data.value};
                        held_next[s_data.channel] = s_data.note_number;
                        last_time_next = lt_adv;
                    end
                end
                mese_pkg::CMD_NOTE_OFF: begin
                    if (ch_ok && held_cur != 7'd0) begin
                        q_push         = 1'b1;
                        q_data.b0      = {mese_pkg::STAT_NOTE_OFF, 2'b00, s_data.channel};
                        q_data.b1      = {1'b0, held_cur};
                        q_data.b2      = 8'h00;
                        held_next[s_data.channel] = 7'd0;
                        last_time_next = lt_adv;
                    end
                end
                mese_pkg::CMD_PAN: begin
                    if (ch_ok && !muted) begin
                        q_push         = 1'b1;
                        q_data.b0      = {mese_pkg::STAT_CTRL, 2'b00, s_data.channel};
                        q_data.b1      = mese_pkg::CTRL_PAN;
                        q_data.b2      = {1'b0, s_data.value};
                        last_time_next = lt_adv;
                    end
                end
                mese_pkg::CMD_EOT: begin
                    // Timed at the current base: delta is zero, base holds.
                    q_push       = 1'b1;
                    q_data.delta = '0;
                    q_data.top   = 2'd0;
                    q_data.b0    = mese_pkg::META_PREFIX;
                    q_data.b1    = mese_pkg::META_EOT;
                    q_data.b2    = 8'h00;
                end
                mese_pkg::CMD_RESTART: begin
                    last_time_next = '0;
                    for (int c = 0; c < mese_pkg::CHANNELS; c++) begin
                        held_next[c] = 7'd0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mute_reg      <= 4'd0;
            last_time_reg <= '0;
            for (int c = 0; c < mese_pkg::CHANNELS; c++) begin
                held_reg[c] <= 7'd0;
            end
        end else begin
            if (cfg_we) begin
                mute_reg <= cfg_wdata;
            end
            last_time_reg <= last_time_next;
            for (int c = 0; c < mese_pkg::CHANNELS; c++) begin
                held_reg[c] <= held_next[c];
            end
        end
    end

endmodule

// File: hw/rtl/mese_evq.sv
// Short event queue between the front and back ends of the MIDI event stream
// encoder. Register-based, one push and one pop per cycle. Uses mese_pkg.
module mese_evq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mese_pkg::ev_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output mese_pkg::ev_t pop_data
);

    mese_pkg::ev_t                  ent_reg [mese_pkg::EVQ_DEPTH];
    logic [mese_pkg::EVQ_PTR_W-1:0] wr_ptr_reg;
    logic [mese_pkg::EVQ_PTR_W-1:0] rd_ptr_reg;
    logic [mese_pkg::EVQ_CNT_W-1:0] count_reg;
    logic                           do_push;
    logic                           do_pop;

    assign full      = (count_reg == mese_pkg::EVQ_CNT_W'(mese_pkg::EVQ_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = ent_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: hw/rtl/mese_back.sv
// Back end of the MIDI event stream encoder: serializes one queued event into
// VLQ delta and 3 event bytes, one per cycle unless stalled. Uses mese_pkg.
module mese_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  mese_pkg::ev_t q_data,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output mese_pkg::out_t m_data
);

    mese_pkg::ev_t  cur_reg;
    logic           cur_valid_reg;
    logic [2:0]     pos_reg;
    logic           m_valid_reg;
    mese_pkg::out_t m_data_reg;

    logic           out_free;
    logic           emit;
    logic           fin;
    logic           load;
    logic [1:0]     grp;
    logic [1:0]     k;
    logic [6:0]     grp_bits;
    logic [7:0]     byte_sel;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = cur_valid_reg && out_free;
    assign fin      = (pos_reg == ({1'b0, cur_reg.top} + 3'd3));
    assign load     = !cur_valid_reg || (emit && fin);
    assign q_pop    = load && q_valid;

    assign grp = cur_reg.top - pos_reg[1:0];
    assign k   = pos_reg[1:0] - cur_reg.top - 2'd1;

    always_comb begin
        case (grp)
            2'd0:    grp_bits = cur_reg.delta[6:0];
            2'd1:    grp_bits = cur_reg.delta[13:7];
            2'd2:    grp_bits = cur_reg.delta[20:14];
            default: grp_bits = cur_reg.delta[27:21];
        endcase
    end

    always_comb begin
        if (pos_reg <= {1'b0, cur_reg.top}) begin
            // Continuation bit on every delta byte but the last.
            byte_sel = {(pos_reg != {1'b0, cur_reg.top}), grp_bits};
        end else begin
            case (k)
                2'd0:    byte_sel = cur_reg.b0;
                2'd1:    byte_sel = cur_reg.b1;
                default: byte_sel = cur_reg.b2;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
        if (emit) begin
            m_data_reg.out_byte <= byte_sel;
            m_data_reg.last     <= fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= 3'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (load) begin
                cur_valid_reg <= q_valid;
                pos_reg       <= 3'd0;
            end else if (emit) begin
                pos_reg <= pos_reg + 3'd1;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hw/rtl/midi_event_stream_encoder.sv
// Top level of the MIDI event stream encoder: front end, event queue, back end.
// Depends on mese_pkg, mese_front, mese_evq and mese_back.
//
//  Channel  | Ports                          | Carries
//  ---------+--------------------------------+-------------------------------------------
//  input    | s_valid, s_ready, s_data       | in_t: command, time, channel, note, value
//  result   | m_valid, m_ready, m_data       | out_t: one track byte, last flag
//  config   | cfg_we, cfg_wdata              | mute_mask, written at once
//
// The front end takes one event per cycle while the four-entry event queue has
// room; state (time base, held notes) is updated in the accepting cycle.
// The back end emits one byte per cycle unless the output stalls; an event is 4 to 7
// bytes (1 to 4 VLQ delta bytes plus 3 event bytes), set by the byte serializer.
// A registered output stage holds each byte; m_ready reaches the serializer
// directly, so a stalled output holds the serializer, and a full queue drops s_ready.
// Synchronous active-low reset clears the time base, held notes, mute mask,
// queue pointers and output valid.
module midi_event_stream_encoder (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [3:0]      cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  mese_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output mese_pkg::out_t  m_data
);

    // Queue links between the front and back ends.
    logic          q_push;
    logic          q_full;
    mese_pkg::ev_t q_push_data;
    logic          q_pop;
    logic          q_valid;
    mese_pkg::ev_t q_pop_data;

    // Classify events, hold mute and note state, compute the delta time.
    mese_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_push_data)
    );

    // Buffer events so each side can stall on its own.
    mese_evq u_evq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_pop_data)
    );

    // Serialize each event into track bytes, one transaction per byte.
    mese_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_pop_data),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// File: tb/midi_event_stream_encoder_test.sv
// Self-checking testbench for midi_event_stream_encoder: directed table plus random
// event traffic, each output byte compared with a built-in track encoder model.
// Depends on mese_pkg and the encoder RTL only.
module midi_event_stream_encoder_test;

    localparam int LIMIT_CYCLES = 400_000;
    localparam int DRAIN_CYCLES = 24;   // longest event plus output stage, with margin
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 34;
    localparam logic [55:0] NO_BYTES = '0;

    // One row of the directed script: either a mute mask write or an event.
    // n_typed >= 0 means the expected bytes are spelled out in 'typed',
    // first byte in the most significant used position; -1 defers to the model.
    typedef struct {
        bit            is_mask;
        logic [3:0]    mask;
        mese_pkg::in_t ev;
        int            n_typed;
        logic [55:0]   typed;
    } step_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [3:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    mese_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    mese_pkg::out_t m_data;

    midi_event_stream_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Encoder model state: time base, held note per channel, mute bits.
    logic [63:0] track_time;
    logic [6:0]  held_notes [mese_pkg::CHANNELS];
    logic [3:0]  mute_bits;

    mese_pkg::out_t pending_bytes [$];   // bytes the block still owes, oldest first
    int          events_taken = 0;    // input transactions seen by the monitor
    int          errors = 0;
    int          cycles = 0;
    bit          steady = 1'b0;       // suppress idling on both sides
    logic [63:0] stim_time = '0;      // timestamp stream fed to the random part

    // Expectation attached to the transaction currently offered.
    int          typed_n = -1;
    logic [55:0] typed_bytes = '0;

    step_t       script [$];

    // Model one event: update the state and return the track bytes it produces.
    task automatic track_encode(input mese_pkg::in_t ev, output int nb,
                                output logic [7:0] bytes [7]);
        logic [63:0] span;
        logic [27:0] ticks;
        logic [7:0]  ev_b [3];
        int          top;
        bit          emit;
        bit          timed;
        bit          muted;

        nb = 0;
        emit = 1'b0;
        timed = 1'b1;
        ticks = '0;
        muted = mute_bits[ev.channel];
        case (ev.command)
            mese_pkg::CMD_NOTE_ON: begin
                if (!muted) begin
                    held_notes[ev.channel] = ev.note_number;
                    ev_b = '{{mese_pkg::STAT_NOTE_ON, 2'b00, ev.channel},
                             {1'b0, ev.note_number}, {1'b0, ev.value}};
                    emit = 1'b1;
                end
            end
            mese_pkg::CMD_NOTE_OFF: begin
                // Mute does not apply; only a held note produces bytes.
                if (held_notes[ev.channel] != '0) begin
                    ev_b = '{{mese_pkg::STAT_NOTE_OFF, 2'b00, ev.channel},
                             {1'b0, held_notes[ev.channel]}, 8'h00};
                    held_notes[ev.channel] = '0;
                    emit = 1'b1;
                end
            end
            mese_pkg::CMD_PAN: begin
                if (!muted) begin
                    ev_b = '{{mese_pkg::STAT_CTRL, 2'b00, ev.channel}, mese_pkg::CTRL_PAN,
                             {1'b0, ev.value}};
                    emit = 1'b1;
                end
            end
            mese_pkg::CMD_EOT: begin
                // Timed at the current time base: delta is always zero.
                ev_b = '{mese_pkg::META_PREFIX, mese_pkg::META_EOT, 8'h00};
                emit = 1'b1;
                timed = 1'b0;
            end
            mese_pkg::CMD_RESTART: begin
                track_time = '0;
                foreach (held_notes[c]) held_notes[c] = '0;
            end
            default: ;
        endcase
        if (!emit) return;

        if (timed) begin
            span = ev.cycle_time - track_time;
            if ((span >> mese_pkg::TICK_SHIFT) > 64'(mese_pkg::DELTA_MAX))
                ticks = mese_pkg::DELTA_MAX;
            else
                ticks = span[mese_pkg::TICK_SHIFT +: mese_pkg::DELTA_W];
            // Advance only by what was emitted, so saturation loses time on purpose.
            track_time = track_time + (64'(ticks) << mese_pkg::TICK_SHIFT);
        end

        // Standard VLQ: skip leading zero groups only, keep interior ones.
        top = 0;
        for (int g = 3; g > 0; g--) begin
            if (top == 0 && ticks[7*g +: 7] != '0) top = g;
        end
        for (int g = top; g > 0; g--) begin
            bytes[nb] = {1'b1, ticks[7*g +: 7]};
            nb++;
        end
        bytes[nb] = {1'b0, ticks[6:0]};
        nb++;
        for (int i = 0; i < 3; i++) begin
            bytes[nb] = ev_b[i];
            nb++;
        end
    endtask

    task automatic flag(input string what);
        errors++;
        if (errors <= 10) $display("%0t: %s", $time, what);
    endtask

    // Monitor: sample both channels at the rising edge, predict on input
    // transactions, compare on output transactions.
    always @(posedge aclk) begin : monitor
        logic [7:0]     pb [7];
        int             nb;
        mese_pkg::out_t want;

        if (aresetn) begin
            if (cfg_we) mute_bits = cfg_wdata;
            if (s_valid && s_ready) begin
                track_encode(s_data, nb, pb);
                // Typed rows override the model's bytes but the model state still advances.
                if (typed_n >= 0) begin
                    nb = typed_n;
                    for (int i = 0; i < nb; i++) pb[i] = typed_bytes[8*(nb-1-i) +: 8];
                end
                for (int i = 0; i < nb; i++) begin
                    want.out_byte = pb[i];
                    want.last = (i == nb - 1);
                    pending_bytes.push_back(want);
                end
                events_taken++;
            end
            if (m_valid && m_ready) begin
                if (pending_bytes.size() == 0) begin
                    flag($sformatf("unexpected byte %02h last %0b", m_data.out_byte,
                                   m_data.last));
                end else begin
                    want = pending_bytes.pop_front();
                    if (m_data.out_byte !== want.out_byte)
                        flag($sformatf("byte: expected %02h, got %02h", want.out_byte,
                                       m_data.out_byte));
                    if (m_data.last !== want.last)
                        flag($sformatf("last flag on byte %02h: expected %0b, got %0b",
                                       want.out_byte, want.last, m_data.last));
                end
            end
        end
    end

    // Watchdog: bail out once the run reaches LIMIT_CYCLES, as when the stream stalls.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("midi_event_stream_encoder_test: errors");
            $finish;
        end
    end

    // Pick an idle stretch: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Output side backpressure: bursts of ready, short stalls, rare long stalls.
    initial begin : ready_gen
        int r;
        int n;
        forever begin
            @(negedge aclk);
            if (steady) begin
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    m_ready <= 1'b1;
                    n = $urandom_range(1, 20);
                end else if (r < 90) begin
                    m_ready <= 1'b0;
                    n = $urandom_range(1, 3);
                end else begin
                    m_ready <= 1'b0;
                    n = $urandom_range(10, 40);
                end
                repeat (n - 1) @(negedge aclk);
            end
        end
    end

    task automatic add_event(input logic [2:0] cmd, input logic [63:0] t, input logic [1:0] ch,
                             input logic [6:0] note, input logic [6:0] val, input int n,
                             input logic [55:0] b);
        step_t s;
        s.is_mask = 1'b0;
        s.mask = '0;
        s.ev.command = cmd;
        s.ev.cycle_time = t;
        s.ev.channel = ch;
        s.ev.note_number = note;
        s.ev.value = val;
        s.n_typed = n;
        s.typed = b;
        script.push_back(s);
    endtask

    task automatic add_mask(input logic [3:0] m);
        step_t s;
        s.is_mask = 1'b1;
        s.mask = m;
        s.ev = '0;
        s.n_typed = -1;
        s.typed = '0;
        script.push_back(s);
    endtask

    // Offer one transaction and hold it until the monitor has seen it accepted.
    task automatic send(input mese_pkg::in_t ev, input int n, input logic [55:0] b);
        int seen;
        seen = events_taken;
        typed_n = n;
        typed_bytes = b;
        s_data <= ev;
        s_valid <= 1'b1;
        do @(negedge aclk); while (events_taken == seen);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    // Drain the output, then allow for events that produced no bytes.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_mask(input logic [3:0] m);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Random event: mostly a forward-moving timeline with assorted gap sizes,
    // plus jumps, backward steps and unused commands.
    function automatic mese_pkg::in_t random_event();
        mese_pkg::in_t ev;
        int            r;
        r = $urandom_range(0, 99);
        if (r < 35) ev.command = mese_pkg::CMD_NOTE_ON;
        else if (r < 60) ev.command = mese_pkg::CMD_NOTE_OFF;
        else if (r < 80) ev.command = mese_pkg::CMD_PAN;
        else if (r < 88) ev.command = mese_pkg::CMD_EOT;
        else if (r < 94) ev.command = mese_pkg::CMD_RESTART;
        else ev.command = 3'(mese_pkg::CMD_RESTART + $urandom_range(1, 3));

        r = $urandom_range(0, 99);
        if (r < 40)
            stim_time += 64'($urandom_range(0, 3 << mese_pkg::TICK_SHIFT));
        else if (r < 65)
            stim_time += (64'($urandom_range(1, 127)) << mese_pkg::TICK_SHIFT)
                         + 64'($urandom_range(0, 16383));
        else if (r < 80)
            stim_time += 64'($urandom) << $urandom_range(0, mese_pkg::TICK_SHIFT);
        else if (r < 88)  // single high group: interior zero groups in the delta
            stim_time += (64'd1 << (mese_pkg::TICK_SHIFT + 7 * $urandom_range(1, 3)))
                         + 64'($urandom_range(0, 16383));
        else if (r < 95)
            stim_time = {$urandom, $urandom};
        else
            stim_time -= 64'($urandom_range(1, 1 << 20));

        ev.cycle_time = stim_time;
        ev.channel = 2'($urandom_range(0, mese_pkg::CHANNELS - 1));
        ev.note_number = 7'($urandom_range(0, 127));
        ev.value = 7'($urandom_range(0, 127));
        if (ev.command == mese_pkg::CMD_RESTART) stim_time = 64'($urandom_range(0, 1 << 16));
        return ev;
    endfunction

    initial begin : stimulus
        logic [3:0] phase_mask [PHASES];
        int         steady_phase;

        track_time = '0;
        foreach (held_notes[c]) held_notes[c] = '0;
        mute_bits = '0;

        // Directed script. Expectations are spelled out where they are obvious.
        add_event(mese_pkg::CMD_EOT, '1, 2'd0, 7'd0, 7'd0, 4, 56'h00_FF2F00);     // fresh track
        add_event(mese_pkg::CMD_NOTE_OFF, 64'd0, 2'd0, 7'd0, 7'd0, 0, NO_BYTES); // nothing held
        add_event(mese_pkg::CMD_NOTE_ON, 64'd0, 2'd0, 7'h7F, 7'h7F, 4, 56'h00_907F7F);
        add_event(mese_pkg::CMD_NOTE_ON, 64'h3FFF, 2'd3, 7'h00, 7'h00, 4, 56'h00_930000);
        add_event(mese_pkg::CMD_NOTE_OFF, 64'h3FFF, 2'd3, 7'h12, 7'h34, 0,
                  NO_BYTES);                                                   // note 0 is none
        add_event(mese_pkg::CMD_PAN, 64'h4000, 2'd1, 7'h00, 7'h40, 4, 56'h01_B10A40);
        add_event(mese_pkg::CMD_NOTE_ON, 64'h20_0000, 2'd2, 7'h3C, 7'h64, 4, 56'h7F_923C64);
        add_event(mese_pkg::CMD_NOTE_OFF, 64'h40_0000, 2'd0, 7'h00, 7'h55, 5,
                  56'h8100_807F00);
        add_event(mese_pkg::CMD_RESTART, 64'hDEAD_BEEF, 2'd1, 7'h01, 7'h01, 0, NO_BYTES);
        add_event(mese_pkg::CMD_NOTE_OFF, 64'd5, 2'd2, 7'h00, 7'h00, 0,
                  NO_BYTES);                                                   // cleared by restart
        add_event(mese_pkg::CMD_PAN, 64'd1 << 35, 2'd0, 7'h00, 7'h05, 7, 56'h818080_00B00A05);
        add_event(mese_pkg::CMD_RESTART, 64'd0, 2'd0, 7'h00, 7'h00, 0, NO_BYTES);
        add_event(mese_pkg::CMD_PAN, 64'd1 << 28, 2'd1, 7'h00, 7'h7F, 6, 56'h818000_B10A7F);
        add_event(mese_pkg::CMD_RESTART, 64'd0, 2'd0, 7'h00, 7'h00, 0, NO_BYTES);
        add_event(mese_pkg::CMD_NOTE_ON, '1, 2'd1, 7'h55, 7'h2A, 7,
                  56'hFFFFFF7F_91552A);                                        // saturate
        add_event(mese_pkg::CMD_NOTE_OFF, 64'd0, 2'd1, 7'h00, 7'h00, 7,
                  56'hFFFFFF7F_815500);                                        // wrap
        add_event(mese_pkg::CMD_EOT, 64'd123, 2'd2, 7'h00, 7'h00, 4, 56'h00_FF2F00);
        add_event(3'(mese_pkg::CMD_RESTART + 1), 64'hFFFF_0000, 2'd3, 7'h7F, 7'h7F, 0,
                  NO_BYTES);
        add_event(3'(mese_pkg::CMD_RESTART + 3), 64'h0, 2'd0, 7'h00, 7'h00, 0, NO_BYTES);
        add_event(mese_pkg::CMD_NOTE_ON, 64'h0123_4567_89AB_CDEF, 2'd0, 7'h11, 7'h22, -1,
                  NO_BYTES);
        add_mask(4'hF);
        add_event(mese_pkg::CMD_NOTE_ON, 64'h0123_4567_89AC_0000, 2'd1, 7'h33, 7'h44, 0,
                  NO_BYTES);
        add_event(mese_pkg::CMD_PAN, 64'h0123_4567_89AD_0000, 2'd2, 7'h00, 7'h2B, 0,
                  NO_BYTES);
        add_event(mese_pkg::CMD_NOTE_OFF, 64'h0123_4567_8A00_0000, 2'd0, 7'h00, 7'h00, -1,
                  NO_BYTES);
        add_event(mese_pkg::CMD_EOT, 64'd0, 2'd3, 7'h00, 7'h00, 4, 56'h00_FF2F00);
        add_mask(4'h0);

        // Hold reset, then release it on a falling edge.
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (script[i]) begin
            if (script[i].is_mask) begin
                write_mask(script[i].mask);
            end else begin
                send(script[i].ev, script[i].n_typed, script[i].typed);
                idle_gap(pick_gap());
            end
        end

        // Random phases, each under its own mute mask; one runs with no idling.
        phase_mask = '{4'h0, 4'hF, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 4'h0};
        steady_phase = $urandom_range(0, PHASES - 1);
        for (int p = 0; p < PHASES; p++) begin
            write_mask(phase_mask[p]);
            steady = (p == steady_phase);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send(random_event(), -1, NO_BYTES);
                idle_gap(pick_gap());
            end
        end
        steady = 1'b0;

        // Drain and give stray bytes a chance to show up before the verdict.
        settle();
        if (errors == 0) begin
            $display("midi_event_stream_encoder_test: clean");
        end else begin
            $display("midi_event_stream_encoder_test: errors");
        end
        $finish;
    end

endmodule
